// File: sv/acmm_pkg.sv
package acmm_pkg;

   localparam int MAX_CHANNELS = 10;
   localparam int SAMPLE_BITS  = 24;
   localparam int COEF_BITS    = 16;
   localparam int COEF_FRAC    = COEF_BITS - 4;
   localparam int CH_BITS      = 4;
   localparam int CSR_BITS     = 4;
   localparam int CSR_IDX_BITS = 2;

   localparam int SMP_ADDR_BITS  = $clog2(MAX_CHANNELS);
   localparam int COEF_DEPTH     = MAX_CHANNELS * MAX_CHANNELS;
   localparam int COEF_ADDR_BITS = $clog2(COEF_DEPTH);
   localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS       = PROD_BITS + CH_BITS;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(1 << COEF_FRAC);
   localparam logic signed [COEF_BITS-1:0] COEF_HALF = COEF_BITS'(1 << (COEF_FRAC - 1));
   localparam logic signed [COEF_BITS-1:0] COEF_P7   =
      COEF_BITS'((7 * (1 << COEF_FRAC) + 5) / 10);
   localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IN_CHANNELS  = 2'd0,
      CSR_OUT_CHANNELS = 2'd1,
      CSR_USE_MATRIX   = 2'd2
   } csr_index_type;

   // request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_FLUSH,
      ST_ROUND
   } state_type;

   // zero acts as one, anything above the maximum as the maximum
   function automatic logic [CH_BITS-1:0] clamp_count(input logic [CH_BITS-1:0] n);
      logic [CH_BITS-1:0] res;
      if (n == '0) begin
         res = CH_BITS'(1);
      end else if (32'(n) > MAX_CHANNELS) begin
         res = CH_BITS'(MAX_CHANNELS);
      end else begin
         res = n;
      end
      return res;
   endfunction

   function automatic logic fixed_pair(input logic [CH_BITS-1:0] ni,
                                       input logic [CH_BITS-1:0] no);
      return (ni == 4'd1 && no == 4'd2) || (ni == 4'd2 && no == 4'd1) ||
             (no == 4'd2 && (ni == 4'd4 || ni == 4'd5 || ni == 4'd6));
   endfunction

   // weight of input c into output r for the built-in converters and passthrough
   function automatic logic signed [COEF_BITS-1:0] fixed_coef(
      input logic [CH_BITS-1:0] ni,
      input logic [CH_BITS-1:0] no,
      input logic [CH_BITS-1:0] r,
      input logic [CH_BITS-1:0] c);
      logic [CH_BITS:0] cw;
      logic [CH_BITS:0] rw;
      logic signed [COEF_BITS-1:0] k;
      cw = {1'b0, c};
      rw = {1'b0, r};
      k  = COEF_ZERO;
      if (ni == 4'd1 && no == 4'd2) begin
         k = (c == 4'd0) ? COEF_ONE : COEF_ZERO;
      end else if (ni == 4'd2 && no == 4'd1) begin
         k = COEF_HALF;
      end else if (ni == 4'd4 && no == 4'd2) begin
         if (c == r) begin
            k = COEF_ONE;
         end else if (cw == rw + 5'd2) begin
            k = COEF_P7;
         end
      end else if (ni == 4'd5 && no == 4'd2) begin
         if (c == r) begin
            k = COEF_ONE;
         end else if (c == 4'd2) begin
            k = COEF_HALF;
         end else if (cw == rw + 5'd3) begin
            k = COEF_ONE;
         end
      end else if (ni == 4'd6 && no == 4'd2) begin
         if (c == r) begin
            k = COEF_ONE;
         end else if (c == 4'd2 || c == 4'd3) begin
            k = COEF_HALF;
         end else if (cw == rw + 5'd4) begin
            k = COEF_HALF;
         end
      end else begin
         k = (c == r) ? COEF_ONE : COEF_ZERO;
      end
      return k;
   endfunction

endpackage

// File: sv/acmm_ram.sv
module acmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/audio_channel_matrix_mixer_core.sv
// Interleaved audio channel mixer. Requests are either audio samples (Q1.23) or
// coefficient writes (Q3.12) into a 10 x 10 matrix; a frame is in_channels
// samples, and on its last sample the block emits one mixed sample per output
// channel, the last marked with frame_last. With use_matrix set each output is
// the sum of sample times loaded coefficient; otherwise the built-in 1>2, 2>1,
// 4>2, 5>2 and 6>2 converters apply, and any other pair passes the frame
// through. Sums are rounded to nearest (ties up) and saturated to 24 bits.
// A coefficient write or a sample that does not close a frame is taken while the
// block is idle. The closing sample starts a frame computation of count outputs,
// count being the number of outputs and ni the input count, done by a single
// shared multiply-accumulate that reads one sample and one coefficient per cycle
// from two single-port-read memories; per output that is ni issue steps, a drain
// of the read and multiply stages and a rounding step, which waits while the
// consumer holds back a waiting result. Requests are not taken during that time,
// but the last result may still wait in the output register while new requests
// come in. Configuration is to be written by the user only while idle, which the
// block itself does not enforce; coefficients must be written before a matrix
// frame reads them.
module audio_channel_matrix_mixer_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_kind,
   input  logic signed [acmm_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic [acmm_pkg::CH_BITS-1:0]            req_coef_row,
   input  logic [acmm_pkg::CH_BITS-1:0]            req_coef_col,
   input  logic signed [acmm_pkg::COEF_BITS-1:0]   req_coef_value,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [acmm_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [acmm_pkg::CH_BITS-1:0]            rsp_out_channel,
   output logic                                    rsp_frame_last,
   // configuration port
   input  logic                                    csr_write,
   input  logic [acmm_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [acmm_pkg::CSR_BITS-1:0]           csr_wdata
);

   import acmm_pkg::*;

   // configuration registers
   logic [CH_BITS-1:0] in_channels_ff;
   logic [CH_BITS-1:0] out_channels_ff;
   logic               use_matrix_ff;

   // sequencer state
   state_type                 state_ff, state_in;
   logic [CH_BITS-1:0]        pos_ff, pos_in;
   logic [CH_BITS-1:0]        row_ff, row_in;
   logic [CH_BITS-1:0]        col_ff, col_in;
   logic [COEF_ADDR_BITS-1:0] rbase_ff, rbase_in;

   // mac pipeline
   logic                        p1_vld_ff, p2_vld_ff;
   logic signed [COEF_BITS-1:0] fixc_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [CH_BITS-1:0]            rsp_chan_ff;
   logic                          rsp_last_ff;

   // derived channel counts
   logic [CH_BITS-1:0] ni, no, count;
   logic               last_col, last_row, out_free;

   // control
   logic req_take, smp_wr, coef_wr, frame_done, issue, load_out;

   // memory ports
   logic [SAMPLE_BITS-1:0]    smp_rd;
   logic [COEF_BITS-1:0]      coef_rd;
   logic [COEF_ADDR_BITS-1:0] coef_wr_addr;
   logic [COEF_ADDR_BITS-1:0] coef_rd_addr;

   // datapath
   logic signed [COEF_BITS-1:0]            coef_sel;
   logic signed [ACC_BITS-1:0]             acc_rnd;
   logic signed [ACC_BITS-COEF_FRAC-1:0]   acc_shr;
   logic signed [SAMPLE_BITS-1:0]          sat_val;

   localparam logic signed [ACC_BITS-COEF_FRAC-1:0] SAT_HI =
      (ACC_BITS-COEF_FRAC)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_BITS-COEF_FRAC-1:0] SAT_LO =
      (ACC_BITS-COEF_FRAC)'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   assign ni       = clamp_count(in_channels_ff);
   assign no       = clamp_count(out_channels_ff);
   assign count    = (use_matrix_ff || fixed_pair(ni, no)) ? no : ni;
   assign last_col = (col_ff + 4'd1 == ni);
   assign last_row = (row_ff + 4'd1 == count);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // frame closes when the position reaches or passes the last input channel
   assign frame_done = ({1'b0, pos_ff} + 5'd1 >= {1'b0, ni});

   // ---------------- control outputs ----------------
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      req_take  = req_valid && !req_stall;
      smp_wr    = req_take && (req_kind == KIND_SAMPLE) && (32'(pos_ff) < MAX_CHANNELS);
      coef_wr   = req_take && (req_kind == KIND_COEF) &&
                  (32'(req_coef_row) < MAX_CHANNELS) && (32'(req_coef_col) < MAX_CHANNELS);
      issue     = (state_ff == ST_MAC);
      load_out  = (state_ff == ST_ROUND) && out_free;
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_kind == KIND_SAMPLE && frame_done) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (last_col) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!p1_vld_ff && !p2_vld_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (out_free) begin
               state_in = last_row ? ST_IDLE : ST_MAC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- counters ----------------
   always_comb begin
      pos_in   = pos_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      rbase_in = rbase_ff;
      if (req_take && req_kind == KIND_SAMPLE) begin
         pos_in   = frame_done ? '0 : pos_ff + 4'd1;
         row_in   = '0;
         col_in   = '0;
         rbase_in = '0;
      end
      if (issue) begin
         col_in = last_col ? '0 : col_ff + 4'd1;
      end
      if (load_out && !last_row) begin
         row_in   = row_ff + 4'd1;
         rbase_in = rbase_ff + COEF_ADDR_BITS'(MAX_CHANNELS);
      end
   end

   // ---------------- memories ----------------
   assign coef_wr_addr = COEF_ADDR_BITS'(req_coef_row) * COEF_ADDR_BITS'(MAX_CHANNELS) +
                         COEF_ADDR_BITS'(req_coef_col);
   assign coef_rd_addr = rbase_ff + COEF_ADDR_BITS'(col_ff);

   // gathered frame, one entry per input channel
   acmm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_CHANNELS)
   ) u_smp_ram (
      .clock   (clock),
      .wr_en   (smp_wr),
      .wr_addr (pos_ff[SMP_ADDR_BITS-1:0]),
      .wr_data (req_sample_in),
      .rd_addr (col_ff[SMP_ADDR_BITS-1:0]),
      .rd_data (smp_rd)
   );

   // coefficient matrix, row-major by output channel
   acmm_ram #(
      .WIDTH (COEF_BITS),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (coef_wr_addr),
      .wr_data (req_coef_value),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd)
   );

   // ---------------- datapath ----------------
   assign coef_sel = use_matrix_ff ? signed'(coef_rd) : fixc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (req_take || load_out) begin
         acc_in = '0;
      end else if (p2_vld_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   // round half up, arithmetic shift, then clamp to the sample range
   assign acc_rnd = acc_ff + ACC_BITS'(COEF_HALF);
   assign acc_shr = acc_rnd[ACC_BITS-1:COEF_FRAC];

   always_comb begin
      priority if (acc_shr > SAT_HI) begin
         sat_val = SAT_HI[SAMPLE_BITS-1:0];
      end else if (acc_shr < SAT_LO) begin
         sat_val = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sat_val = acc_shr[SAMPLE_BITS-1:0];
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_channels_ff  <= CH_BITS'(2);
         out_channels_ff <= CH_BITS'(2);
         use_matrix_ff   <= 1'b0;
         state_ff        <= ST_IDLE;
         pos_ff          <= '0;
         row_ff          <= '0;
         col_ff          <= '0;
         rbase_ff        <= '0;
         p1_vld_ff       <= 1'b0;
         p2_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_IN_CHANNELS:  in_channels_ff  <= csr_wdata[CH_BITS-1:0];
               CSR_OUT_CHANNELS: out_channels_ff <= csr_wdata[CH_BITS-1:0];
               CSR_USE_MATRIX:   use_matrix_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rbase_ff     <= rbase_in;
         p1_vld_ff    <= issue;
         p2_vld_ff    <= p1_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fixc_ff <= fixed_coef(ni, no, row_ff, col_ff);
      prod_ff <= signed'(smp_rd) * coef_sel;
      acc_ff  <= acc_in;
      if (load_out) begin
         rsp_sample_ff <= sat_val;
         rsp_chan_ff   <= row_ff;
         rsp_last_ff   <= last_row;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_frame_last  = rsp_last_ff;

`ifndef SYNTHESIS
   // mac pipeline only runs while a frame is being computed
   a_pipe_in_frame: assert property (@(posedge clock) disable iff (reset)
      (p1_vld_ff || p2_vld_ff) |-> (state_ff == ST_MAC || state_ff == ST_FLUSH))
      else $error("mac pipeline active outside frame computation");

   // gather position never leaves the sample store
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < MAX_CHANNELS)
      else $error("channel position out of range");

   // issued column stays below the input channel count
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (col_ff < ni))
      else $error("mac column beyond input channels");

   // emitted channel index stays below the output count
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (row_ff < count))
      else $error("output row beyond output count");

   // the marked result ends the frame and frees the request side
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (load_out && last_row) |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("frame did not end after last result");
`endif

endmodule

// File: verif/tb_top.sv
module tb_top;
   import acmm_pkg::*;

   // clocking and run length
   localparam int     HALF_PERIOD    = 5;
   localparam int     RESET_CYCLES   = 10;
   // quiet cycles after the last owed result, covers a sample still being stored
   localparam int     SETTLE_CYCLES  = 8;
   localparam int     GAP_MAX        = 18;
   localparam int     SQUEEZE_CYCLES = 400;
   localparam int     RANDOM_ITEMS   = 300;
   localparam int     SQUEEZE_PHASE  = 3;
   // generous wall on the run time
   localparam longint RUN_LIMIT      = 64'd10_000_000;

   // register index with no register behind it
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_NIL = '0;

   // fixed converter weights in q3.12
   localparam longint W_UNITY = longint'(1) << COEF_FRAC;
   localparam longint W_HALF  = W_UNITY / 2;
   localparam longint W_0P7   = (7 * W_UNITY + 5) / 10;

   // one request as the sender offers it
   typedef struct packed {
      logic                          kind;
      logic signed [SAMPLE_BITS-1:0] smp;
      logic [CH_BITS-1:0]            row;
      logic [CH_BITS-1:0]            col;
      logic signed [COEF_BITS-1:0]   cval;
   } mix_req_type;

   // one mixed output sample
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] smp;
      logic [CH_BITS-1:0]            chan;
      logic                          last;
   } mix_out_type;

   // directed table: register writes and requests, some with outputs typed in
   typedef enum logic {PLAN_CSR, PLAN_REQ} plan_kind_type;

   typedef struct packed {
      plan_kind_type                 kind;
      logic [CSR_IDX_BITS-1:0]       reg_idx;
      logic [CSR_BITS-1:0]           reg_val;
      mix_req_type                   rq;
      logic [1:0]                    n_typed;
      logic signed [SAMPLE_BITS-1:0] typed_a;
      logic signed [SAMPLE_BITS-1:0] typed_b;
   } plan_row_type;

   // dut ports
   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_kind;
   logic signed [SAMPLE_BITS-1:0] req_sample_in;
   logic [CH_BITS-1:0]            req_coef_row;
   logic [CH_BITS-1:0]            req_coef_col;
   logic signed [COEF_BITS-1:0]   req_coef_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic [CH_BITS-1:0]            rsp_out_channel;
   logic                          rsp_frame_last;
   logic                          csr_write;
   logic [CSR_IDX_BITS-1:0]       csr_index;
   logic [CSR_BITS-1:0]           csr_wdata;

   // mixer state as the testbench sees it
   logic [CH_BITS-1:0]            model_in;
   logic [CH_BITS-1:0]            model_out;
   logic                          model_use_matrix;
   logic signed [SAMPLE_BITS-1:0] model_frame [MAX_CHANNELS];
   int                            model_pos;
   logic signed [COEF_BITS-1:0]   model_coef [MAX_CHANNELS][MAX_CHANNELS];
   bit                            coef_loaded [MAX_CHANNELS][MAX_CHANNELS];

   // outputs still owed by the block, oldest first
   mix_out_type  owed_mix[$];
   mix_out_type  fresh_mix[$];
   plan_row_type plan[$];

   int errors        = 0;
   int results_taken = 0;
   int send_gap_max  = 0;
   int sink_gap_max  = 0;
   bit squeeze_armed = 1'b0;

   audio_channel_matrix_mixer_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_sample_in   (req_sample_in),
      .req_coef_row    (req_coef_row),
      .req_coef_col    (req_coef_col),
      .req_coef_value  (req_coef_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_out_channel (rsp_out_channel),
      .rsp_frame_last  (rsp_frame_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // zero acts as one channel, anything past the maximum as the maximum
   function automatic int lanes(input logic [CH_BITS-1:0] n);
      int v;
      v = int'(n);
      if (v < 1) begin
         v = 1;
      end else if (v > MAX_CHANNELS) begin
         v = MAX_CHANNELS;
      end
      return v;
   endfunction

   // channel pairs that have a built-in converter
   function automatic bit is_converter(input int ni, input int no);
      bit hit;
      hit = 1'b0;
      if (no == 1) begin
         hit = (ni == 2);
      end else if (no == 2) begin
         hit = (ni == 1) || (ni >= 4 && ni <= 6);
      end
      return hit;
   endfunction

   // weight of input c into output r without the loaded matrix
   function automatic longint fixed_weight(input int ni, input int no, input int r, input int c);
      longint w;
      w = (c == r) ? W_UNITY : 0;
      if (no == 1 && ni == 2) begin
         w = W_HALF;
      end else if (no == 2) begin
         case (ni)
            1: w = (c == 0) ? W_UNITY : 0;
            4: if (c == r + 2) w = W_0P7;
            5: begin
               if (c == 2) begin
                  w = W_HALF;
               end else if (c == r + 3) begin
                  w = W_UNITY;
               end
            end
            6: if (c == 2 || c == 3 || c == r + 4) w = W_HALF;
            default: ;
         endcase
      end
      return w;
   endfunction

   // advance the mixer state by one accepted request, outputs land in fresh_mix
   function automatic void mix_request(input mix_req_type rq);
      int          ni;
      int          no;
      int          outs;
      int          r;
      int          c;
      longint      acc;
      longint      w;
      mix_out_type o;
      ni = lanes(model_in);
      no = lanes(model_out);
      fresh_mix.delete();
      if (rq.kind == KIND_COEF) begin
         // out of range indexes are dropped, the frame is untouched
         if (rq.row < MAX_CHANNELS && rq.col < MAX_CHANNELS) begin
            model_coef[rq.row][rq.col]  = rq.cval;
            coef_loaded[rq.row][rq.col] = 1'b1;
         end
         return;
      end
      model_frame[model_pos] = rq.smp;
      // after a count change mid frame, a position at or past the end closes it
      if (model_pos + 1 < ni) begin
         model_pos++;
         return;
      end
      model_pos = 0;
      outs = (model_use_matrix || is_converter(ni, no)) ? no : ni;
      for (r = 0; r < outs; r++) begin
         acc = 0;
         for (c = 0; c < ni; c++) begin
            w = model_use_matrix ? longint'(model_coef[r][c]) : fixed_weight(ni, no, r, c);
            acc += longint'(model_frame[c]) * w;
         end
         // round to nearest, ties toward plus infinity, then clip to 24 bits
         acc = (acc + W_HALF) >>> COEF_FRAC;
         if (acc > S_MAX) begin
            acc = S_MAX;
         end else if (acc < S_MIN) begin
            acc = S_MIN;
         end
         o.smp  = SAMPLE_BITS'(acc);
         o.chan = CH_BITS'(r);
         o.last = (r == outs - 1);
         fresh_mix.push_back(o);
      end
   endfunction

   function automatic plan_row_type plan_csr(input logic [CSR_IDX_BITS-1:0] idx,
                                             input logic [CSR_BITS-1:0] val);
      plan_row_type p;
      p         = '0;
      p.kind    = PLAN_CSR;
      p.reg_idx = idx;
      p.reg_val = val;
      return p;
   endfunction

   function automatic plan_row_type plan_sample(input logic signed [SAMPLE_BITS-1:0] v,
                                                input logic [1:0] n = 2'd0,
                                                input logic signed [SAMPLE_BITS-1:0] ta = '0,
                                                input logic signed [SAMPLE_BITS-1:0] tb = '0);
      plan_row_type p;
      p         = '0;
      p.kind    = PLAN_REQ;
      p.rq.kind = KIND_SAMPLE;
      p.rq.smp  = v;
      p.n_typed = n;
      p.typed_a = ta;
      p.typed_b = tb;
      return p;
   endfunction

   function automatic plan_row_type plan_coef(input logic [CH_BITS-1:0] r,
                                              input logic [CH_BITS-1:0] c,
                                              input logic signed [COEF_BITS-1:0] v);
      plan_row_type p;
      p         = '0;
      p.kind    = PLAN_REQ;
      p.rq.kind = KIND_COEF;
      p.rq.row  = r;
      p.rq.col  = c;
      p.rq.cval = v;
      return p;
   endfunction

   // coefficient mix: extremes, values within plus or minus unity, full range
   function automatic logic signed [COEF_BITS-1:0] draw_coef();
      logic signed [COEF_BITS-1:0] v;
      case ($urandom_range(0, 7))
         0: v = {1'b0, {(COEF_BITS-1){1'b1}}};
         1: v = {1'b1, {(COEF_BITS-1){1'b0}}};
         2, 3: v = COEF_BITS'($urandom_range(0, 8192)) - COEF_BITS'(4096);
         default: v = COEF_BITS'($urandom);
      endcase
      return v;
   endfunction

   // idle ceiling for the next stretch: none, light or full
   function automatic int pick_gap_ceiling();
      int g;
      case ($urandom_range(0, 2))
         0: g = 0;
         1: g = 4;
         default: g = GAP_MAX;
      endcase
      return g;
   endfunction

   // offer one request and hold it until taken, entered and left at a falling edge
   task automatic offer(input mix_req_type rq, input logic [1:0] n_typed,
                        input logic signed [SAMPLE_BITS-1:0] ta,
                        input logic signed [SAMPLE_BITS-1:0] tb);
      int          gap;
      int          k;
      mix_out_type o;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= rq.kind;
      req_sample_in  <= rq.smp;
      req_coef_row   <= rq.row;
      req_coef_col   <= rq.col;
      req_coef_value <= rq.cval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mix_request(rq);
      if (n_typed == 2'd0) begin
         foreach (fresh_mix[k]) owed_mix.push_back(fresh_mix[k]);
      end else begin
         // outputs read straight off the spec for this row
         for (k = 0; k < int'(n_typed); k++) begin
            o.smp  = (k == 0) ? ta : tb;
            o.chan = CH_BITS'(k);
            o.last = (k == int'(n_typed) - 1);
            owed_mix.push_back(o);
         end
      end
      @(negedge clock);
   endtask

   // stop offering, wait for every owed output, then let the block settle
   task automatic drain_to_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (owed_mix.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [CSR_BITS-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_IN_CHANNELS:  model_in         = val;
         CSR_OUT_CHANNELS: model_out        = val;
         CSR_USE_MATRIX:   model_use_matrix = val[0];
         default: ;
      endcase
   endtask

   // result side: random stall per output, one long hold-off when armed
   initial begin : result_sink
      int          hold;
      mix_out_type want;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (squeeze_armed) begin
            squeeze_armed = 1'b0;
            hold          = SQUEEZE_CYCLES;
         end else begin
            hold = $urandom_range(0, sink_gap_max);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (owed_mix.size() == 0) begin
            $display("%0t: expected no output, got sample_out %0d out_channel %0d frame_last %0b",
                     $time, rsp_sample_out, rsp_out_channel, rsp_frame_last);
            errors++;
         end else begin
            want = owed_mix.pop_front();
            if (rsp_sample_out !== want.smp) begin
               $display("%0t: sample_out expected %0d got %0d", $time,
                        $signed(want.smp), rsp_sample_out);
               errors++;
            end
            if (rsp_out_channel !== want.chan) begin
               $display("%0t: out_channel expected %0d got %0d", $time,
                        want.chan, rsp_out_channel);
               errors++;
            end
            if (rsp_frame_last !== want.last) begin
               $display("%0t: frame_last expected %0b got %0b", $time,
                        want.last, rsp_frame_last);
               errors++;
            end
         end
         results_taken++;
         // new idle profile every few dozen outputs
         if (results_taken % 40 == 0) sink_gap_max = pick_gap_ceiling();
         @(negedge clock);
      end
   end

   // safety net against a hung handshake
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("FAIL audio_channel_matrix_mixer_core");
      $finish;
   end

   initial begin : stimulus
      mix_req_type        rq;
      int                 made;
      int                 phase;
      int                 burst;
      int                 i;
      int                 r;
      int                 c;
      logic [CH_BITS-1:0] ni_reg;
      logic [CH_BITS-1:0] no_reg;
      logic               mtx;

      // every input known from time zero
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_SAMPLE;
      req_sample_in  = '0;
      req_coef_row   = '0;
      req_coef_col   = '0;
      req_coef_value = '0;
      csr_write      = 1'b0;
      csr_index      = CSR_IN_CHANNELS;
      csr_wdata      = '0;

      // state after reset: 2 in, 2 out, passthrough, empty frame
      model_in         = CH_BITS'(2);
      model_out        = CH_BITS'(2);
      model_use_matrix = 1'b0;
      model_pos        = 0;
      foreach (model_frame[k]) model_frame[k] = '0;
      for (r = 0; r < MAX_CHANNELS; r++) begin
         for (c = 0; c < MAX_CHANNELS; c++) begin
            model_coef[r][c]  = '0;
            coef_loaded[r][c] = 1'b0;
         end
      end

      plan = '{
         // spare index write must leave the reset setup alone
         plan_csr(CSR_SPARE, 4'hF),
         plan_sample(S_MAX),
         plan_sample(S_MIN, 2'd2, S_MAX, S_MIN),
         // zero input channels acts as one: mono copied to both sides
         plan_csr(CSR_IN_CHANNELS, 4'd0),
         plan_csr(CSR_OUT_CHANNELS, 4'd2),
         plan_sample(-24'sd1, 2'd2, -24'sd1, -24'sd1),
         // stereo to mono, half-way ties round up on both sides of zero
         plan_csr(CSR_IN_CHANNELS, 4'd2),
         plan_csr(CSR_OUT_CHANNELS, 4'd1),
         plan_sample(24'sd1),
         plan_sample(24'sd0, 2'd1, 24'sd1, S_NIL),
         plan_sample(-24'sd1),
         plan_sample(24'sd0, 2'd1, 24'sd0, S_NIL),
         // quad to stereo at full scale clips high
         plan_csr(CSR_IN_CHANNELS, 4'd4),
         plan_csr(CSR_OUT_CHANNELS, 4'd2),
         plan_sample(S_MAX),
         plan_sample(S_MAX),
         plan_sample(S_MAX),
         plan_sample(S_MAX, 2'd2, S_MAX, S_MAX),
         // five to stereo at negative full scale clips low
         plan_csr(CSR_IN_CHANNELS, 4'd5),
         plan_sample(S_MIN),
         plan_sample(S_MIN),
         plan_sample(S_MIN),
         plan_sample(S_MIN),
         plan_sample(S_MIN, 2'd2, S_MIN, S_MIN),
         // six to stereo with mixed content
         plan_csr(CSR_IN_CHANNELS, 4'd6),
         plan_sample(24'sh123456),
         plan_sample(-24'sh002000),
         plan_sample(24'sh400000),
         plan_sample(24'sh3FFFFF),
         plan_sample(-24'sd7),
         plan_sample(24'sh000800),
         // matrix 1x1: weight -8 on the most negative sample clips high,
         // writes past the matrix edge are dropped
         plan_csr(CSR_IN_CHANNELS, 4'd0),
         plan_csr(CSR_OUT_CHANNELS, 4'd0),
         plan_csr(CSR_USE_MATRIX, 4'd1),
         plan_coef(4'd0, 4'd0, 16'sh8000),
         plan_coef(4'd12, 4'd3, 16'sh1234),
         plan_coef(4'd3, 4'd15, -16'sd1),
         plan_sample(S_MIN, 2'd1, S_MAX, S_NIL)
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (plan[k]) begin
         if (plan[k].kind == PLAN_CSR) begin
            drain_to_idle();
            write_reg(plan[k].reg_idx, plan[k].reg_val);
         end else begin
            offer(plan[k].rq, plan[k].n_typed, plan[k].typed_a, plan[k].typed_b);
         end
      end

      // random phases; each ends wherever it stops, so frames often straddle a
      // setup change
      made  = 0;
      phase = 0;
      while (made < RANDOM_ITEMS) begin
         phase++;
         drain_to_idle();
         send_gap_max = pick_gap_ceiling();
         if (phase == SQUEEZE_PHASE) begin
            // mono to stereo back to back while the result side holds off
            ni_reg       = CH_BITS'(1);
            no_reg       = CH_BITS'(2);
            mtx          = 1'b0;
            send_gap_max = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            // a built-in converter pair, now and then through the matrix
            case ($urandom_range(0, 4))
               0: begin ni_reg = CH_BITS'(1); no_reg = CH_BITS'(2); end
               1: begin ni_reg = CH_BITS'(2); no_reg = CH_BITS'(1); end
               2: begin ni_reg = CH_BITS'(4); no_reg = CH_BITS'(2); end
               3: begin ni_reg = CH_BITS'(5); no_reg = CH_BITS'(2); end
               default: begin ni_reg = CH_BITS'(6); no_reg = CH_BITS'(2); end
            endcase
            mtx = ($urandom_range(0, 3) == 0);
         end else begin
            ni_reg = CH_BITS'($urandom_range(0, 15));
            no_reg = CH_BITS'($urandom_range(0, 15));
            mtx    = 1'($urandom_range(0, 1));
         end
         write_reg(CSR_IN_CHANNELS, ni_reg);
         write_reg(CSR_OUT_CHANNELS, no_reg);
         // upper bits of the matrix flag are don't-care
         write_reg(CSR_USE_MATRIX, {3'($urandom_range(0, 7)), mtx});
         if ($urandom_range(0, 4) == 0) write_reg(CSR_SPARE, CSR_BITS'($urandom));

         // fill every matrix entry this setup can read that was never loaded
         if (mtx) begin
            for (r = 0; r < lanes(no_reg); r++) begin
               for (c = 0; c < lanes(ni_reg); c++) begin
                  if (!coef_loaded[r][c]) begin
                     rq      = '0;
                     rq.kind = KIND_COEF;
                     rq.smp  = SAMPLE_BITS'($urandom);
                     rq.row  = CH_BITS'(r);
                     rq.col  = CH_BITS'(c);
                     rq.cval = draw_coef();
                     offer(rq, 2'd0, S_NIL, S_NIL);
                     made++;
                  end
               end
            end
         end

         if (phase == SQUEEZE_PHASE) squeeze_armed = 1'b1;

         burst = $urandom_range(6, 40);
         for (i = 0; i < burst; i++) begin
            // unused fields carry noise
            rq.smp  = SAMPLE_BITS'($urandom);
            rq.row  = CH_BITS'($urandom);
            rq.col  = CH_BITS'($urandom);
            rq.cval = COEF_BITS'($urandom);
            if (phase == SQUEEZE_PHASE || $urandom_range(0, 99) < 85) begin
               rq.kind = KIND_SAMPLE;
               case ($urandom_range(0, 7))
                  0: rq.smp = S_MAX;
                  1: rq.smp = S_MIN;
                  default: ;
               endcase
            end else begin
               rq.kind = KIND_COEF;
               if ($urandom_range(0, 4) != 0) begin
                  rq.row = CH_BITS'($urandom_range(0, MAX_CHANNELS - 1));
                  rq.col = CH_BITS'($urandom_range(0, MAX_CHANNELS - 1));
               end
               rq.cval = draw_coef();
            end
            offer(rq, 2'd0, S_NIL, S_NIL);
            // dropped coefficient writes do not count
            if (rq.kind == KIND_SAMPLE || (rq.row < MAX_CHANNELS && rq.col < MAX_CHANNELS)) begin
               made++;
            end
         end
      end

      drain_to_idle();
      if (errors == 0) begin
         $display("PASS audio_channel_matrix_mixer_core");
      end else begin
         $display("FAIL audio_channel_matrix_mixer_core");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/acmm_pkg.sv
sv/acmm_ram.sv
sv/audio_channel_matrix_mixer_core.sv
verif/tb_top.sv
